### src/int8_dot_product_shift_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the int8 dot product block
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while reset is held.
// ----------------------------------------------------------------------------
`ifndef INT8_DOT_PRODUCT_SHIFT_TOP_DEFINES_SVH
`define INT8_DOT_PRODUCT_SHIFT_TOP_DEFINES_SVH

// Same-cycle implication
`define IDP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define IDP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/idp_pkg.sv
// ----------------------------------------------------------------------------
// idp_pkg
// Widths, register map and shared types of the int8 dot product block.
// ----------------------------------------------------------------------------
package idp_pkg;

    // Lane counts
    localparam int LANES_DEF  = 8;
    localparam int WORD_LANES = 8;   // bytes carried by one 64-bit field

    // Datapath widths
    localparam int BYTE_W  = 8;
    localparam int DATA_W  = 64;
    localparam int PROD_W  = 16;
    localparam int ACC_W   = 32;
    localparam int SHIFT_W = 5;

    // Register port
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 3;
    localparam int REG_IDX_W = APB_AW - 2;
    localparam logic [REG_IDX_W-1:0] REG_RESULT_SHIFT = 1'b0;

    // Control that travels with each stage
    typedef struct packed {
        logic valid;
        logic last;
    } t_ctl;

endpackage

### src/idp_lane.sv
// ----------------------------------------------------------------------------
// idp_lane
// One multiply lane: signed 8x8 product, registered.
// ----------------------------------------------------------------------------
module idp_lane import idp_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [BYTE_W-1:0]        i_act,
    input  logic [BYTE_W-1:0]        i_wgt,
    output logic signed [PROD_W-1:0] o_prod
);

    logic signed [PROD_W-1:0] n_act_ext;
    logic signed [PROD_W-1:0] n_wgt_ext;
    logic signed [PROD_W-1:0] n_prod;
    logic signed [PROD_W-1:0] r_prod;

    // sign-extend both bytes, product fits exactly in 16 bits
    assign n_act_ext = {{(PROD_W-BYTE_W){i_act[BYTE_W-1]}}, i_act};
    assign n_wgt_ext = {{(PROD_W-BYTE_W){i_wgt[BYTE_W-1]}}, i_wgt};
    assign n_prod    = n_act_ext * n_wgt_ext;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;

endmodule

### src/idp_merge.sv
// ----------------------------------------------------------------------------
// idp_merge
// Sums the lane products into one registered partial sum.
// ----------------------------------------------------------------------------
module idp_merge import idp_pkg::*; #(
    parameter int NL    = LANES_DEF,
    parameter int SUM_W = PROD_W + $clog2(LANES_DEF)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  t_ctl                     i_ctl,
    input  logic signed [PROD_W-1:0] i_prods [NL],
    output t_ctl                     o_ctl,
    output logic signed [SUM_W-1:0]  o_sum
);

    logic signed [SUM_W-1:0] n_sum;
    logic signed [SUM_W-1:0] r_sum;
    t_ctl                    r_ctl;

    // adder tree over the lanes
    always_comb begin
        n_sum = '0;
        for (int k = 0; k < NL; k++) begin
            n_sum = n_sum + SUM_W'(i_prods[k]);
        end
    end

    // control valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    // partial sum, no reset
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum <= n_sum;
        end
    end

    assign o_ctl = r_ctl;
    assign o_sum = r_sum;

endmodule

### src/idp_accum.sv
// ----------------------------------------------------------------------------
// idp_accum
// Wrapping 32-bit accumulator, result shift and output register.
// ----------------------------------------------------------------------------
`include "int8_dot_product_shift_top_defines.svh"

module idp_accum import idp_pkg::*; #(
    parameter int SUM_W = PROD_W + $clog2(LANES_DEF)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_stall,
    input  t_ctl                    i_ctl,
    input  logic signed [SUM_W-1:0] i_sum,
    input  logic [SHIFT_W-1:0]      i_shift,
    output logic                    o_adv,
    output logic                    o_valid,
    output logic [ACC_W-1:0]        o_result
);

    logic [ACC_W-1:0] r_running_sum;
    logic [ACC_W-1:0] n_total;
    logic [ACC_W-1:0] r_fin;
    logic             r_fin_valid;
    logic [ACC_W-1:0] n_out;
    logic [ACC_W-1:0] r_out;
    logic             r_out_valid;
    logic             w_hold;

    // result held while the consumer stalls it
    assign w_hold = r_out_valid && i_stall;

    // upstream stops only when a finished sum waits behind a held result
    assign o_adv = !(w_hold && r_fin_valid);

    // accumulate, wraps mod 2^32
    assign n_total = r_running_sum + ACC_W'(i_sum);

    // arithmetic shift of the finished sum
    assign n_out = ACC_W'($signed(r_fin) >>> i_shift);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running_sum <= '0;
            r_fin_valid   <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (o_adv) begin
                if (i_ctl.valid) begin
                    r_running_sum <= i_ctl.last ? '0 : n_total;
                end
                r_fin_valid <= i_ctl.valid && i_ctl.last;
            end
            if (!w_hold) begin
                r_out_valid <= r_fin_valid;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_fin <= n_total;
        end
        if (!w_hold) begin
            r_out <= n_out;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    // checks
    `IDP_ASSERT_NEXT(a_sum_cleared, i_clk, i_rst_n, o_adv && i_ctl.valid && i_ctl.last, r_running_sum == '0, "running sum not cleared after last chunk")
    `IDP_ASSERT_IMPL(a_out_from_last, i_clk, i_rst_n, $rose(o_valid), $past(r_fin_valid), "result without a finished sum")
    `IDP_ASSERT_NEXT(a_frozen_holds, i_clk, i_rst_n, !o_adv, $stable(r_running_sum) && $stable(r_out_valid), "state moved while pipeline frozen")

endmodule

### src/int8_dot_product_shift_top.sv
// ----------------------------------------------------------------------------
// int8_dot_product_shift_top
// Signed 8-bit dot product accumulator with shifted 32-bit result.
//
//   channel   direction  handshake          payload
//   -------   ---------  ---------          -------
//   input     in         i_valid / o_stall  i_act_bytes, i_weight_bytes, i_last_chunk
//   output    out        o_valid / i_stall  o_dot_result
//   config    in         APB psel/penable   paddr, pwdata, prdata
//
// One request per cycle while o_stall is low; a result reaches the output
// register through the lane multiply, adder tree, accumulate and shift
// registers once the request marked last is accepted.
// Reset clears the running sum, all stage valid bits and result_shift.
// A stalled result blocks requests only while a finished sum waits behind it;
// o_stall then follows i_stall in the same cycle.
// ----------------------------------------------------------------------------
module int8_dot_product_shift_top import idp_pkg::*; #(
    parameter int LANES = LANES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input channel
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [DATA_W-1:0]   i_act_bytes,
    input  logic [DATA_W-1:0]   i_weight_bytes,
    input  logic                i_last_chunk,
    // output channel
    output logic                o_valid,
    input  logic                i_stall,
    output logic signed [ACC_W-1:0] o_dot_result,
    // register port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready
);

    // lanes past the eighth carry no bytes
    localparam int NL    = (LANES < WORD_LANES) ? LANES : WORD_LANES;
    localparam int SUM_W = PROD_W + $clog2(NL);

    logic                     w_adv;
    logic                     w_out_valid;
    logic [ACC_W-1:0]         w_result;
    t_ctl                     r_s1_ctl;
    t_ctl                     w_s2_ctl;
    logic signed [PROD_W-1:0] w_prods [NL];
    logic signed [SUM_W-1:0]  w_sum;
    logic [SHIFT_W-1:0]       r_result_shift;
    logic                     w_wr;

    // pipeline advance comes from the accumulator stage
    assign o_stall = !w_adv;

    // stage 1 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl <= '0;
        end else if (w_adv) begin
            r_s1_ctl.valid <= i_valid;
            r_s1_ctl.last  <= i_last_chunk;
        end
    end

    // multiply lanes
    for (genvar g = 0; g < NL; g++) begin : g_lane
        idp_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (w_adv),
            .i_act  (i_act_bytes[g*BYTE_W +: BYTE_W]),
            .i_wgt  (i_weight_bytes[g*BYTE_W +: BYTE_W]),
            .o_prod (w_prods[g])
        );
    end

    // adder tree
    idp_merge #(
        .NL    (NL),
        .SUM_W (SUM_W)
    ) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_ctl   (r_s1_ctl),
        .i_prods (w_prods),
        .o_ctl   (w_s2_ctl),
        .o_sum   (w_sum)
    );

    // accumulator and output register
    idp_accum #(
        .SUM_W (SUM_W)
    ) u_accum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_stall  (i_stall),
        .i_ctl    (w_s2_ctl),
        .i_sum    (w_sum),
        .i_shift  (r_result_shift),
        .o_adv    (w_adv),
        .o_valid  (w_out_valid),
        .o_result (w_result)
    );

    assign o_valid      = w_out_valid;
    assign o_dot_result = $signed(w_result);

    // register writes
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_result_shift <= '0;
        end else if (w_wr && (paddr[APB_AW-1:2] == REG_RESULT_SHIFT)) begin
            r_result_shift <= pwdata[SHIFT_W-1:0];
        end
    end

    // register reads
    always_comb begin
        case (paddr[APB_AW-1:2])
            REG_RESULT_SHIFT: prdata = {{(APB_DW-SHIFT_W){1'b0}}, r_result_shift};
            default:          prdata = '0;
        endcase
    end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench for int8_dot_product_shift_top
// Streams chunks of packed signed bytes into the accumulator with random
// gaps on the request side and random stalls on the result side. A local
// predictor accumulates each accepted chunk and queues the shifted sum on
// every chunk marked last, and the monitor checks results in order.
// The shift register is rewritten between phases, only once the block is idle.
// ----------------------------------------------------------------------------
module testbench import idp_pkg::*; ();

    localparam int SETTLE_CYCLES  = 10;
    localparam int STUCK_LIMIT    = 4000;  // cycles with no handshake at all
    localparam int GAP_PERCENT    = 30;
    localparam int RANDOM_PHASES  = 5;
    localparam int PHASE_CHUNKS   = 95;

    localparam logic [APB_AW-1:0] ADDR_RESULT_SHIFT = APB_AW'(REG_RESULT_SHIFT) << 2;
    localparam logic [APB_AW-1:0] ADDR_SPARE        = APB_AW'(REG_RESULT_SHIFT + 1) << 2;

    localparam logic [DATA_W-1:0] BYTES_MIN  = {WORD_LANES{8'h80}};
    localparam logic [DATA_W-1:0] BYTES_MAX  = {WORD_LANES{8'h7F}};
    localparam logic [DATA_W-1:0] BYTES_NEG1 = {WORD_LANES{8'hFF}};
    localparam logic [DATA_W-1:0] BYTES_ONE  = {WORD_LANES{8'h01}};

    typedef struct {
        logic [DATA_W-1:0] act;
        logic [DATA_W-1:0] wt;
        logic              last;
    } t_chunk;

    // DUT signals
    logic                    i_clk          = 1'b0;
    logic                    i_rst_n        = 1'b0;
    logic                    i_valid        = 1'b0;
    logic                    o_stall;
    logic [DATA_W-1:0]       i_act_bytes    = '0;
    logic [DATA_W-1:0]       i_weight_bytes = '0;
    logic                    i_last_chunk   = 1'b0;
    logic                    o_valid;
    logic                    i_stall        = 1'b0;
    logic signed [ACC_W-1:0] o_dot_result;
    logic                    psel           = 1'b0;
    logic                    penable        = 1'b0;
    logic                    pwrite         = 1'b0;
    logic [APB_AW-1:0]       paddr          = '0;
    logic [APB_DW-1:0]       pwdata         = '0;
    logic [APB_DW-1:0]       prdata;
    logic                    pready;

    // Predictor state and scoreboard
    t_chunk                  pending_chunks[$];
    logic signed [ACC_W-1:0] expected_dots[$];
    logic [ACC_W-1:0]        sum_model   = '0;
    logic [SHIFT_W-1:0]      shift_model = '0;
    logic                    no_gaps     = 1'b0;
    int                      error_count = 0;
    int                      stuck_cycles = 0;

    int8_dot_product_shift_top i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_act_bytes    (i_act_bytes),
        .i_weight_bytes (i_weight_bytes),
        .i_last_chunk   (i_last_chunk),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_dot_result   (o_dot_result),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #6 i_clk = ~i_clk;

    // Sum of the signed byte products of one chunk, wrapped to 32 bits
    function automatic logic [ACC_W-1:0] chunk_dot(logic [DATA_W-1:0] act,
                                                   logic [DATA_W-1:0] wt);
        logic signed [BYTE_W-1:0] a;
        logic signed [BYTE_W-1:0] w;
        logic signed [ACC_W-1:0]  acc;
        acc = '0;
        for (int i = 0; i < WORD_LANES; i++) begin
            a   = act[i*BYTE_W +: BYTE_W];
            w   = wt[i*BYTE_W +: BYTE_W];
            acc = acc + ACC_W'(a) * ACC_W'(w);
        end
        return acc;
    endfunction

    // Fold an accepted request into the running sum; close the product on last
    task automatic accumulate_chunk(logic [DATA_W-1:0] act, logic [DATA_W-1:0] wt,
                                    logic last);
        logic signed [ACC_W-1:0] total;
        total     = sum_model + chunk_dot(act, wt);
        sum_model = total;
        if (last) begin
            expected_dots.push_back(total >>> shift_model);
            sum_model = '0;
        end
    endtask

    function automatic logic take_gap();
        if (no_gaps)
            return 1'b0;
        return $urandom_range(0, 99) < GAP_PERCENT;
    endfunction

    // Packed bytes biased toward the signed extremes
    function automatic logic [DATA_W-1:0] rand_bytes();
        logic [DATA_W-1:0] w;
        int unsigned       pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return BYTES_MIN;
        if (pick == 1)
            return BYTES_MAX;
        w = {$urandom, $urandom};
        if (pick < 5) begin
            for (int i = 0; i < WORD_LANES; i++) begin
                case ($urandom_range(0, 7))
                    0: w[i*BYTE_W +: BYTE_W] = 8'h80;
                    1: w[i*BYTE_W +: BYTE_W] = 8'h7F;
                    2: w[i*BYTE_W +: BYTE_W] = 8'hFF;
                    3: w[i*BYTE_W +: BYTE_W] = 8'h00;
                    default: ;
                endcase
            end
        end
        return w;
    endfunction

    task automatic queue_chunk(logic [DATA_W-1:0] act, logic [DATA_W-1:0] wt,
                               logic last);
        t_chunk c;
        c.act  = act;
        c.wt   = wt;
        c.last = last;
        pending_chunks.push_back(c);
    endtask

    task automatic report_mismatch(string field, logic signed [ACC_W-1:0] got,
                                   logic signed [ACC_W-1:0] want);
        $display("%0t mismatch %s: got %0d expected %0d", $realtime, field, got, want);
        error_count++;
    endtask

    // Wait until every request is accepted and every result is back, then
    // let the pipeline run empty. Checked on the falling edge to stay clear
    // of the processes working on the rising one.
    task automatic wait_idle();
        @(negedge i_clk);
        while (pending_chunks.size() != 0 || i_valid || expected_dots.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register write: setup cycle, then access cycle until pready
    task automatic write_reg(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr[APB_AW-1:2] == REG_RESULT_SHIFT)
            shift_model = data[SHIFT_W-1:0];
    endtask

    // Extremes, lone single-chunk products, lane placement, a short product
    task automatic queue_directed();
        queue_chunk(BYTES_MIN, BYTES_MIN, 1'b1);
        queue_chunk(BYTES_MAX, BYTES_MIN, 1'b1);
        queue_chunk(BYTES_MAX, BYTES_MAX, 1'b1);
        queue_chunk(BYTES_NEG1, BYTES_ONE, 1'b1);
        queue_chunk('0, BYTES_NEG1, 1'b1);
        for (int i = 0; i < WORD_LANES; i++)
            queue_chunk(DATA_W'(8'h80) << (i * BYTE_W),
                        DATA_W'(i + 1) << (i * BYTE_W), i == WORD_LANES - 1);
        queue_chunk(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 1'b0);
        queue_chunk(64'hFEDC_BA98_7654_3210, 64'h0123_4567_89AB_CDEF, 1'b1);
    endtask

    // Well-formed products of random length with random content
    task automatic queue_random_phase(int n_chunks);
        int count;
        int len;
        count = 0;
        while (count < n_chunks) begin
            if ($urandom_range(0, 9) == 0)
                len = $urandom_range(6, 40);
            else
                len = $urandom_range(1, 5);
            for (int k = 0; k < len; k++)
                queue_chunk(rand_bytes(), rand_bytes(), k == len - 1);
            count += len;
        end
    endtask

    // Request driver
    always @(posedge i_clk) begin : drive_requests
        t_chunk nxt;
        logic   held;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall)
                accumulate_chunk(i_act_bytes, i_weight_bytes, i_last_chunk);
            held = i_valid && o_stall;
            if (!held) begin
                if (pending_chunks.size() != 0 && !take_gap()) begin
                    nxt = pending_chunks.pop_front();
                    i_act_bytes    <= nxt.act;
                    i_weight_bytes <= nxt.wt;
                    i_last_chunk   <= nxt.last;
                    i_valid        <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and stall generator
    always @(posedge i_clk) begin : check_results
        logic signed [ACC_W-1:0] want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_dots.size() == 0) begin
                    report_mismatch("unexpected dot_result", o_dot_result, 'x);
                end else begin
                    want = expected_dots.pop_front();
                    if (o_dot_result !== want)
                        report_mismatch("dot_result", o_dot_result, want);
                end
            end
            i_stall <= take_gap();
        end
    end

    // Count cycles without any handshake
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) ||
            (psel && penable && pwrite && pready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial begin : watchdog
        while (stuck_cycles < STUCK_LIMIT) @(posedge i_clk);
        $display("%0t watchdog: no progress for %0d cycles", $realtime, STUCK_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    // Stimulus sequence
    initial begin : stimulus
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // shift left at its reset value
        queue_directed();
        wait_idle();

        write_reg(ADDR_RESULT_SHIFT, APB_DW'(31));
        queue_directed();
        wait_idle();

        // only the low five bits count; the spare address is ignored
        write_reg(ADDR_RESULT_SHIFT, 32'hFFFF_FFE4);
        write_reg(ADDR_SPARE, 32'h0000_0007);
        queue_directed();
        wait_idle();

        write_reg(ADDR_RESULT_SHIFT, '0);
        queue_directed();
        wait_idle();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            write_reg(ADDR_RESULT_SHIFT, $urandom);
            if (p == 2)
                write_reg(ADDR_SPARE, $urandom);
            no_gaps = (p == 1);
            queue_random_phase(PHASE_CHUNKS);
            wait_idle();
        end
        no_gaps = 1'b0;

        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
